/* sv/glocc_pkg.sv */
// shared types, codes and widths of the grid line occluder counter
package glocc_pkg;

  // fixed field widths
  localparam int COORD_W   = 6;
  localparam int DIM_W     = 7;
  localparam int CNT_W     = 7;
  localparam int OP_W      = 2;
  localparam int ERR_W     = 9;
  localparam int CFG_IDX_W = 1;

  // default grid side and register reset values
  localparam int              GRID_SIDE_DEF = 64;
  localparam logic [DIM_W-1:0] DIM_RESET    = 7'd64;
  localparam logic [CNT_W-1:0] COUNT_MAX    = 7'd127;

  // item operation codes
  typedef enum logic [OP_W-1:0] {
    OP_WR_STATIC  = 2'd0,
    OP_WR_DYNAMIC = 2'd1,
    OP_QUERY      = 2'd2,
    OP_NONE       = 2'd3
  } op_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_ACC,
    ST_DONE
  } state_t;

  // block map write request
  typedef struct packed {
    logic wr_en;
    logic wr_dynamic;
    logic wr_bit;
  } map_req_t;

  // one line step from the shared step unit
  typedef struct packed {
    logic               go_col;
    logic               go_row;
    logic [COORD_W-1:0] ncol;
    logic [COORD_W-1:0] nrow;
    logic [ERR_W-1:0]   nerr;
  } step_t;

endpackage

/* sv/glocc_map.sv */
// static and dynamic block map memory with clearing pass after reset
module glocc_map
  import glocc_pkg::*;
#(
  parameter int GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  map_req_t                                  req,
  input  logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0]    addr,
  output logic                                      rd_blocked,
  output logic                                      busy
);

  localparam int TILE_COUNT = GRID_SIDE * GRID_SIDE;
  localparam int AW         = $clog2(TILE_COUNT);

  logic static_mem  [TILE_COUNT];
  logic dynamic_mem [TILE_COUNT];

  logic [AW-1:0] clr_addr_r;
  logic          busy_r;
  logic          rd_blocked_r;

  // clearing sweep, one tile a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      busy_r     <= 1'b1;
    end else if (busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(TILE_COUNT - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // static bit writes
  always_ff @(posedge clk) begin
    if (busy_r) begin
      static_mem[clr_addr_r] <= 1'b0;
    end else if (req.wr_en && !req.wr_dynamic) begin
      static_mem[addr] <= req.wr_bit;
    end
  end

  // dynamic bit writes
  always_ff @(posedge clk) begin
    if (busy_r) begin
      dynamic_mem[clr_addr_r] <= 1'b0;
    end else if (req.wr_en && req.wr_dynamic) begin
      dynamic_mem[addr] <= req.wr_bit;
    end
  end

  // registered read, tile blocked when either bit is set
  always_ff @(posedge clk) begin
    rd_blocked_r <= static_mem[addr] | dynamic_mem[addr];
  end

  assign rd_blocked = rd_blocked_r;
  assign busy       = busy_r;

endmodule

/* sv/glocc_step.sv */
// bresenham step unit: next position and error term from the current one
module glocc_step
  import glocc_pkg::*;
(
  input  logic [COORD_W-1:0] col,
  input  logic [COORD_W-1:0] row,
  input  logic [ERR_W-1:0]   err,
  input  logic [COORD_W-1:0] dc,
  input  logic [COORD_W-1:0] dr,
  input  logic               col_up,
  input  logic               row_up,
  output step_t              step
);

  logic signed [ERR_W:0] err_s;
  logic signed [ERR_W:0] e2;
  logic signed [ERR_W:0] dc_s;
  logic signed [ERR_W:0] dr_s;
  logic signed [ERR_W:0] nerr_s;

  always_comb begin
    err_s = $signed({err[ERR_W-1], err});
    e2    = err_s <<< 1;
    dc_s  = $signed({{(ERR_W+1-COORD_W){1'b0}}, dc});
    dr_s  = $signed({{(ERR_W+1-COORD_W){1'b0}}, dr});

    // direction decisions
    step.go_col = e2 > -dr_s;
    step.go_row = e2 < dc_s;

    // error update
    nerr_s = err_s;
    if (step.go_col) begin
      nerr_s = nerr_s - dr_s;
    end
    if (step.go_row) begin
      nerr_s = nerr_s + dc_s;
    end
    step.nerr = nerr_s[ERR_W-1:0];

    // coordinates stay inside the bounding box of the endpoints
    step.ncol = col;
    if (step.go_col) begin
      step.ncol = col_up ? col + COORD_W'(1) : col - COORD_W'(1);
    end
    step.nrow = row;
    if (step.go_row) begin
      step.nrow = row_up ? row + COORD_W'(1) : row - COORD_W'(1);
    end
  end

endmodule

/* sv/grid_line_occluder_counter_unit.sv */
// Grid line occluder counter: keeps a GRID_SIDE x GRID_SIDE map of static and dynamic blocking
// bits and counts blocked tiles (and blocked diagonal corners) on a Bresenham line between two
// tiles. After reset the map is cleared one tile a cycle and no item is taken meanwhile;
// configuration writes are taken at any time and must only arrive while the block is idle.
// A tile write is taken while the block is idle and leaves it idle. A query whose endpoint
// lies outside the grid or whose endpoints coincide gives its result in the cycle after it is
// taken. Otherwise each line step uses the single read port of the block map: a straight step
// reads the new tile and then updates the count, and a diagonal step reads the column-side
// neighbour, the row-side neighbour and the new tile in turn before the update. The next item
// is taken once the result has been taken.
module grid_line_occluder_counter_unit
  import glocc_pkg::*;
#(
  parameter int GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // item input
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      in_operation,
  input  logic [COORD_W-1:0]   in_from_col,
  input  logic [COORD_W-1:0]   in_from_row,
  input  logic [COORD_W-1:0]   in_to_col,
  input  logic [COORD_W-1:0]   in_to_row,
  input  logic                 in_block_value,
  // result output
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CNT_W-1:0]     out_occluder_count,
  output logic                 out_endpoint_invalid,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  localparam int AW = $clog2(GRID_SIDE * GRID_SIDE);

  state_t             state_r, state_nxt;
  logic [DIM_W-1:0]   grid_width_r;
  logic [DIM_W-1:0]   grid_height_r;
  logic [COORD_W-1:0] col_r, row_r, end_col_r, end_row_r;
  logic [COORD_W-1:0] dc_r, dr_r;
  logic               col_up_r, row_up_r;
  logic [ERR_W-1:0]   err_r;
  logic [CNT_W-1:0]   count_r;
  logic               invalid_r;
  logic               side_a_r, side_b_r;

  logic               accept;
  logic               in_bad, in_same, from_ok, to_ok;
  logic [COORD_W-1:0] dc_in, dr_in;
  step_t              step;
  logic               diag, at_end;
  logic [CNT_W:0]     sum;
  map_req_t           map_req;
  logic [AW-1:0]      map_addr;
  logic               rd_blocked;
  logic               map_busy;

  // tile address, row major at the full grid side
  function automatic logic [AW-1:0] tile_addr(input logic [COORD_W-1:0] c,
                                              input logic [COORD_W-1:0] r);
    logic [31:0] full;
    full = 32'(r) * 32'(GRID_SIDE) + 32'(c);
    return full[AW-1:0];
  endfunction

  // tile inside the grid in use
  function automatic logic in_grid(input logic [COORD_W-1:0] c,
                                   input logic [COORD_W-1:0] r,
                                   input logic [DIM_W-1:0]   w,
                                   input logic [DIM_W-1:0]   h);
    return ({1'b0, c} < w) && ({1'b0, r} < h) &&
           (32'(c) < 32'(GRID_SIDE)) && (32'(r) < 32'(GRID_SIDE));
  endfunction

  // block map memory
  glocc_map #(
    .GRID_SIDE (GRID_SIDE)
  ) u_map (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (map_req),
    .addr       (map_addr),
    .rd_blocked (rd_blocked),
    .busy       (map_busy)
  );

  // shared step unit
  glocc_step u_step (
    .col    (col_r),
    .row    (row_r),
    .err    (err_r),
    .dc     (dc_r),
    .dr     (dr_r),
    .col_up (col_up_r),
    .row_up (row_up_r),
    .step   (step)
  );

  // item decode
  assign accept  = in_valid && in_ready;
  assign from_ok = in_grid(in_from_col, in_from_row, grid_width_r, grid_height_r);
  assign to_ok   = in_grid(in_to_col, in_to_row, grid_width_r, grid_height_r);
  assign in_bad  = !(from_ok && to_ok);
  assign in_same = (in_from_col == in_to_col) && (in_from_row == in_to_row);
  assign dc_in   = (in_to_col > in_from_col) ? in_to_col - in_from_col
                                             : in_from_col - in_to_col;
  assign dr_in   = (in_to_row > in_from_row) ? in_to_row - in_from_row
                                             : in_from_row - in_to_row;

  // step status and count update
  assign diag   = step.go_col && step.go_row;
  assign at_end = (step.ncol == end_col_r) && (step.nrow == end_row_r);
  always_comb begin
    sum = {1'b0, count_r} + (CNT_W+1)'(diag && side_a_r && side_b_r)
                          + (CNT_W+1)'(!at_end && rd_blocked);
  end

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= DIM_RESET;
      grid_height_r <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_GRID_WIDTH:  grid_width_r  <= cfg_data;
        CFG_GRID_HEIGHT: grid_height_r <= cfg_data;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (!map_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid && op_t'(in_operation) == OP_QUERY) begin
          state_nxt = (in_bad || in_same) ? ST_DONE : ST_RD_A;
        end
      end
      ST_RD_A: state_nxt = diag ? ST_RD_B : ST_ACC;
      ST_RD_B: state_nxt = ST_RD_C;
      ST_RD_C: state_nxt = ST_ACC;
      ST_ACC:  state_nxt = at_end ? ST_DONE : ST_RD_A;
      ST_DONE: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // handshake and map control
  always_comb begin
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    map_req.wr_en      = 1'b0;
    map_req.wr_dynamic = 1'b0;
    map_req.wr_bit     = in_block_value;
    map_addr       = tile_addr(step.ncol, step.nrow);
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        map_addr = tile_addr(in_from_col, in_from_row);
        map_req.wr_dynamic = (op_t'(in_operation) == OP_WR_DYNAMIC);
        map_req.wr_en = in_valid && from_ok &&
                        (op_t'(in_operation) == OP_WR_STATIC ||
                         op_t'(in_operation) == OP_WR_DYNAMIC);
      end
      ST_RD_A: begin
        // diagonal step reads the column-side neighbour first
        if (diag) begin
          map_addr = tile_addr(step.ncol, row_r);
        end
      end
      ST_RD_B: map_addr = tile_addr(col_r, step.nrow);
      ST_RD_C: map_addr = tile_addr(step.ncol, step.nrow);
      ST_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end

  // walk datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          col_r     <= in_from_col;
          row_r     <= in_from_row;
          end_col_r <= in_to_col;
          end_row_r <= in_to_row;
          dc_r      <= dc_in;
          dr_r      <= dr_in;
          col_up_r  <= in_from_col < in_to_col;
          row_up_r  <= in_from_row < in_to_row;
          err_r     <= ERR_W'({1'b0, dc_in}) - ERR_W'({1'b0, dr_in});
          count_r   <= '0;
          invalid_r <= in_bad;
        end
      end
      ST_RD_B: side_a_r <= rd_blocked;
      ST_RD_C: side_b_r <= rd_blocked;
      ST_ACC: begin
        col_r   <= step.ncol;
        row_r   <= step.nrow;
        err_r   <= step.nerr;
        count_r <= sum[CNT_W] ? COUNT_MAX : sum[CNT_W-1:0];
      end
      default: ;
    endcase
  end

  assign out_occluder_count   = count_r;
  assign out_endpoint_invalid = invalid_r;

`ifndef SYNTHESIS
  // input and output sides are never open together
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("in_ready and out_valid both high");

  // an invalid endpoint always reports a zero count
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_endpoint_invalid) |-> (out_occluder_count == '0))
    else $error("invalid endpoint with nonzero count");

  // a taken query closes the input side
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op_t'(in_operation) == OP_QUERY) |=> !in_ready)
    else $error("input still open after query");

  // every walk step moves the position
  a_step_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD_A) |-> (step.go_col || step.go_row))
    else $error("line step without movement");
`endif

endmodule
